FILE: hw/rtl/kmsb_pkg.sv
package kmsb_pkg;

  localparam int VERTEX_W = 7;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 22;

  typedef enum logic [5:0] {
    ST_LOAD     = 6'b000001,
    ST_SORT_RD  = 6'b000010,
    ST_PASS_INI = 6'b000100,
    ST_EDGE_RD  = 6'b001000,
    ST_EDGE_CHK = 6'b010000,
    ST_OUT      = 6'b100000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write incoming edge
    logic sort_start;  // begin insertion sort
    logic sort_step;   // advance sort by one micro step
    logic pass_init;   // reset parent table and sums
    logic edge_step;   // run one micro step of the edge loop
    logic pass_end;    // close the current pass
    logic clear;       // drop stored edges after result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sort_done;
    logic pass_busy;
    logic all_done;
  } status_t;

endpackage

FILE: hw/rtl/kmsb_datapath.sv
module kmsb_datapath import kmsb_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [VERTEX_W-1:0]        vertex_count,
  input  logic [VERTEX_W-1:0]        from_vertex,
  input  logic [VERTEX_W-1:0]        to_vertex,
  input  logic signed [WEIGHT_W-1:0] edge_weight,
  output logic signed [SUM_W-1:0]    tree_weight,
  output logic signed [SUM_W-1:0]    second_weight,
  output logic                       second_found
);

  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int VA_W  = $clog2(MAX_VERTICES + 1);
  localparam int REC_W = 2 * VERTEX_W + WEIGHT_W;

  // edge memory: {weight, to, from}
  logic [REC_W-1:0] edge_mem [MAX_EDGES];
  logic             mark_mem [MAX_EDGES];
  logic [VA_W-1:0]  parent   [MAX_VERTICES + 1];

  logic [EC_W-1:0]  edge_total;
  logic [EC_W-1:0]  edge_total_next;
  logic [REC_W-1:0] rd_data;
  logic [EA_W-1:0]  rd_addr;
  logic [EA_W-1:0]  sort_addr;
  logic [EA_W-1:0]  pass_addr;
  logic             mark_rd;

  // sort state
  logic [EC_W-1:0]  sort_i;
  logic [EC_W-1:0]  sort_j;
  logic [REC_W-1:0] key;
  logic [2:0]       sort_ph;
  logic             sort_done;

  // pass state
  logic [EC_W-1:0]  idx;
  logic [EC_W-1:0]  skip;
  logic             first_pass;
  logic [EC_W-1:0]  scan;
  logic [VA_W-1:0]  n_eff;
  logic [VA_W-1:0]  init_v;
  logic [3:0]       ph;
  logic [1:0]       lat;
  logic [VA_W-1:0]  ra;
  logic [VA_W-1:0]  rb;
  logic [VA_W-1:0]  walk;
  logic [VA_W-1:0]  par_rd;
  logic signed [SUM_W-1:0] sum;
  logic [VA_W-1:0]  joined;
  logic [REC_W-1:0] cur;
  logic             pass_busy;
  logic             all_done;

  localparam logic [3:0] P_INIT = 4'd0, P_RD = 4'd1, P_CHK = 4'd2, P_FA = 4'd3,
                         P_FB = 4'd4, P_CA = 4'd5, P_CB = 4'd6, P_JN = 4'd7,
                         P_NEXT = 4'd8, P_IDLE = 4'd9;

  localparam logic [2:0] S_RD = 3'd0, S_RD_WAIT = 3'd1, S_KEY = 3'd2,
                         S_CMP_WAIT = 3'd3, S_CMP = 3'd4;

  logic signed [WEIGHT_W-1:0] key_w;
  logic signed [WEIGHT_W-1:0] rd_w;
  logic [VERTEX_W-1:0] cur_f;
  logic [VERTEX_W-1:0] cur_t;

  assign key_w = key[REC_W-1 -: WEIGHT_W];
  assign rd_w  = rd_data[REC_W-1 -: WEIGHT_W];
  assign cur_f = cur[VERTEX_W-1:0];
  assign cur_t = cur[2*VERTEX_W-1:VERTEX_W];

  // the sorter owns the read port until it finishes
  assign rd_addr = sort_done ? pass_addr : sort_addr;

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = VA_W'(1);
    end else if ({{(32-VERTEX_W){1'b0}}, vertex_count} > MAX_VERTICES) begin
      n_eff = VA_W'(MAX_VERTICES);
    end else begin
      n_eff = VA_W'(vertex_count);
    end
  end

  always_comb begin
    edge_total_next = edge_total;
    if (cmd.clear) begin
      edge_total_next = '0;
    end else if (cmd.load && edge_total < EC_W'(MAX_EDGES)) begin
      edge_total_next = edge_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= edge_mem[rd_addr];
    mark_rd <= mark_mem[rd_addr];
    par_rd  <= parent[walk];
  end

  // insertion sort, one element at a time through the registered read port
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      sort_done  <= 1'b0;
      sort_ph    <= S_RD;
    end else begin
      edge_total <= edge_total_next;
      if (cmd.load && edge_total < EC_W'(MAX_EDGES)) begin
        edge_mem[edge_total[EA_W-1:0]] <= {edge_weight, to_vertex, from_vertex};
      end
      if (cmd.sort_start) begin
        sort_i    <= EC_W'(1);
        sort_ph   <= S_RD;
        sort_done <= (edge_total_next <= EC_W'(1));
        sort_addr <= '0;
      end else if (cmd.sort_step && !sort_done) begin
        unique case (sort_ph)
          S_RD: begin
            sort_addr <= sort_i[EA_W-1:0];
            sort_ph   <= S_RD_WAIT;
          end
          S_RD_WAIT: sort_ph <= S_KEY;
          S_KEY: begin
            key       <= rd_data;
            sort_j    <= sort_i;
            sort_addr <= EA_W'(sort_i - 1'b1);
            sort_ph   <= S_CMP_WAIT;
          end
          S_CMP_WAIT: sort_ph <= S_CMP;
          S_CMP: begin
            // shift the heavier neighbor up, or drop the key in its slot
            if (sort_j != '0 && rd_w > key_w) begin
              edge_mem[sort_j[EA_W-1:0]] <= rd_data;
              sort_j    <= sort_j - 1'b1;
              sort_addr <= EA_W'(sort_j - 2'd2);
              sort_ph   <= S_CMP_WAIT;
            end else begin
              edge_mem[sort_j[EA_W-1:0]] <= key;
              sort_i  <= sort_i + 1'b1;
              sort_ph <= S_RD;
              if (sort_i + 1'b1 >= edge_total) sort_done <= 1'b1;
            end
          end
          default: sort_ph <= S_RD;
        endcase
      end
    end
  end

  assign status.sort_done = sort_done;
  assign status.pass_busy = pass_busy;
  assign status.all_done  = all_done;

  // Kruskal passes: first pass marks tree edges, later passes skip one edge
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_busy    <= 1'b0;
      all_done     <= 1'b0;
      ph           <= P_IDLE;
      second_found <= 1'b0;
    end else begin
      if (cmd.sort_start) begin
        first_pass   <= 1'b1;
        skip         <= edge_total_next;
        scan         <= '0;
        second_found <= 1'b0;
        second_weight <= '0;
        all_done     <= 1'b0;
      end
      if (cmd.pass_init) begin
        pass_busy <= 1'b1;
        init_v    <= '0;
        ph        <= P_INIT;
        sum       <= '0;
        joined    <= '0;
        idx       <= '0;
      end else if (cmd.edge_step && pass_busy) begin
        case (ph)
          P_INIT: begin
            parent[init_v] <= init_v;
            if (init_v == VA_W'(MAX_VERTICES)) begin
              ph <= P_RD;
              lat <= '0;
            end
            init_v <= init_v + 1'b1;
          end
          P_RD: begin
            if (idx >= edge_total) begin
              pass_busy <= 1'b0;
              ph <= P_IDLE;
            end else begin
              pass_addr <= idx[EA_W-1:0];
              lat <= '0;
              ph <= P_CHK;
            end
          end
          P_CHK: begin
            if (lat == 2'd1) begin
              cur <= rd_data;
              if (first_pass) mark_mem[idx[EA_W-1:0]] <= 1'b0;
              if (idx == skip ||
                  rd_data[VERTEX_W-1:0] == '0 ||
                  VA_W'(rd_data[VERTEX_W-1:0]) > n_eff ||
                  rd_data[2*VERTEX_W-1:VERTEX_W] == '0 ||
                  VA_W'(rd_data[2*VERTEX_W-1:VERTEX_W]) > n_eff) begin
                ph <= P_NEXT;
              end else begin
                walk <= VA_W'(rd_data[VERTEX_W-1:0]);
                lat <= '0;
                ph <= P_FA;
              end
            end else begin
              lat <= lat + 1'b1;
            end
          end
          P_FA: begin
            if (lat == 2'd1) begin
              if (par_rd == walk) begin
                ra <= walk;
                walk <= VA_W'(cur_f);
                ph <= P_CA;
              end else begin
                walk <= par_rd;
              end
              lat <= '0;
            end else begin
              lat <= lat + 1'b1;
            end
          end
          P_CA: begin
            // compress path of a
            if (lat == 2'd1) begin
              if (par_rd == ra || walk == ra) begin
                walk <= VA_W'(cur_t);
                ph <= P_FB;
              end else begin
                parent[walk] <= ra;
                walk <= par_rd;
              end
              lat <= '0;
            end else begin
              lat <= lat + 1'b1;
            end
          end
          P_FB: begin
            if (lat == 2'd1) begin
              if (par_rd == walk) begin
                rb <= walk;
                walk <= VA_W'(cur_t);
                ph <= P_CB;
              end else begin
                walk <= par_rd;
              end
              lat <= '0;
            end else begin
              lat <= lat + 1'b1;
            end
          end
          P_CB: begin
            if (lat == 2'd1) begin
              if (par_rd == rb || walk == rb) begin
                ph <= P_JN;
              end else begin
                parent[walk] <= rb;
                walk <= par_rd;
              end
              lat <= '0;
            end else begin
              lat <= lat + 1'b1;
            end
          end
          P_JN: begin
            if (ra != rb) begin
              parent[ra] <= rb;
              sum <= sum + SUM_W'(signed'(cur[REC_W-1 -: WEIGHT_W]));
              joined <= joined + 1'b1;
              if (first_pass) mark_mem[idx[EA_W-1:0]] <= 1'b1;
            end
            ph <= P_NEXT;
          end
          P_NEXT: begin
            idx <= idx + 1'b1;
            ph <= P_RD;
          end
          default: ph <= P_IDLE;
        endcase
      end else if (cmd.pass_end) begin
        // record result and start the scan for the next marked edge to skip
        if (first_pass) begin
          tree_weight <= sum;
          first_pass  <= 1'b0;
          scan        <= '0;
        end else begin
          if (joined == n_eff - 1'b1 && (!second_found || sum < second_weight)) begin
            second_weight <= sum;
            second_found  <= 1'b1;
          end
          scan <= scan + 1'b1;
        end
        pass_addr <= first_pass ? '0 : EA_W'(scan + 1'b1);
        ph <= P_IDLE;
        lat <= '0;
      end else if (cmd.edge_step && !pass_busy) begin
        // scanning marks between passes
        if (lat == 2'd1) begin
          lat <= '0;
          if (scan >= edge_total) begin
            all_done <= 1'b1;
          end else if (mark_rd) begin
            skip <= scan;
            pass_busy <= 1'b1;
            init_v <= '0;
            ph <= P_INIT;
            sum <= '0;
            joined <= '0;
            idx <= '0;
          end else begin
            scan <= scan + 1'b1;
            pass_addr <= EA_W'(scan + 1'b1);
          end
        end else begin
          lat <= lat + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/kmsb_ctrl.sv
module kmsb_ctrl import kmsb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    in_last,
  input  logic    out_fire,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready,
  output logic    out_valid
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire && in_last) begin
          cmd.sort_start = 1'b1;
          state_next = ST_SORT_RD;
        end
      end
      ST_SORT_RD: begin
        cmd.sort_step = 1'b1;
        if (status.sort_done) begin
          state_next = ST_PASS_INI;
        end
      end
      ST_PASS_INI: begin
        cmd.pass_init = 1'b1;
        state_next = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        if (status.pass_busy) begin
          cmd.edge_step = 1'b1;
        end else begin
          cmd.pass_end = 1'b1;
          state_next = ST_EDGE_CHK;
        end
      end
      ST_EDGE_CHK: begin
        // look for the next tree edge to leave out
        if (status.all_done) begin
          state_next = ST_OUT;
        end else if (status.pass_busy) begin
          state_next = ST_EDGE_RD;
        end else begin
          cmd.edge_step = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          cmd.clear = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("result shown while loading");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_fire) |=> state == ST_OUT)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_last) |=> state == ST_SORT_RD)
    else $error("last edge did not start sort");

endmodule

FILE: hw/rtl/kruskal_mst_second_best.sv
// Second-best minimum spanning tree engine. Edges load one per transfer at one
// per cycle, while loading, into a MAX_EDGES entry memory; the transfer with
// tlast starts an in-place insertion sort (O(E^2)) and then 1 + T Kruskal
// passes, T being the tree edge count. Each pass resets all MAX_VERTICES+1
// parent table entries, fetches and checks each edge, walks to both roots with
// path compression through a one-read memory, and then closes the edge;
// between passes the tree marks are scanned edge by edge. Intake stalls until
// the single result is taken. vertex_count may be written only while idle; 0
// acts as 1 and values above MAX_VERTICES saturate.
module kruskal_mst_second_best import kmsb_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // from_vertex[6:0], to_vertex[13:7], edge_weight[29:14]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // tree_weight[21:0], second_weight[43:22], second_found[44]
  output logic        m_axis_tlast
);

  logic [VERTEX_W-1:0] vertex_count;
  cmd_t    cmd;
  status_t status;
  logic signed [SUM_W-1:0] tree_weight;
  logic signed [SUM_W-1:0] second_weight;
  logic second_found;
  logic in_fire;
  logic out_fire;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= VERTEX_W'(1);
    else if (cfg_we) vertex_count <= cfg_wdata;
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  kmsb_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_axis_tlast), .out_fire, .status, .cmd,
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  kmsb_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .cmd, .status, .vertex_count,
    .from_vertex(s_axis_tdata[6:0]),
    .to_vertex(s_axis_tdata[13:7]),
    .edge_weight(s_axis_tdata[29:14]),
    .tree_weight, .second_weight, .second_found
  );

  assign m_axis_tdata = {3'b000, second_found, second_weight, tree_weight};
  assign m_axis_tlast = 1'b1;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kmsb_pkg::*;

  localparam int MAX_V      = 64;
  localparam int MAX_E      = 256;
  localparam int IDLE_LIMIT = 10000000;

  typedef struct {
    logic signed [SUM_W-1:0] tree;
    logic signed [SUM_W-1:0] second;
    bit                      found;
  } mst_result_t;

  class mst_scoreboard;
    int unsigned vcount = 1;
    int          errors = 0;
    int          edge_cnt = 0;
    int          ef[MAX_E];
    int          et[MAX_E];
    int          ew[MAX_E];
    int          par[MAX_V+1];
    bit          in_tree[MAX_E];
    mst_result_t results_due[$];

    function int find_root(int v);
      int r, nx;
      r = v;
      while (par[r] != r) r = par[r];
      while (par[v] != r) begin
        nx = par[v];
        par[v] = r;
        v = nx;
      end
      return r;
    endfunction

    function void kruskal_run(int n, int skip, bit mark, output int sum, output int joined);
      int a, b, ra, rb;
      for (int i = 1; i <= n; i++) par[i] = i;
      sum = 0;
      joined = 0;
      for (int i = 0; i < edge_cnt; i++) begin
        if (mark) in_tree[i] = 0;
        if (i == skip) continue;
        a = ef[i];
        b = et[i];
        if (a < 1 || a > n || b < 1 || b > n) continue;
        ra = find_root(a);
        rb = find_root(b);
        if (ra != rb) begin
          par[ra] = rb;
          sum += ew[i];
          joined++;
          if (mark) in_tree[i] = 1;
        end
      end
    endfunction

    function void compute_trees();
      int n, j, f, t, w, sum, joined, best;
      bit found;
      mst_result_t r;
      n = (vcount < 1) ? 1 : (vcount > MAX_V) ? MAX_V : vcount;
      // stable insertion sort by weight
      for (int i = 1; i < edge_cnt; i++) begin
        f = ef[i]; t = et[i]; w = ew[i]; j = i;
        while (j > 0 && ew[j-1] > w) begin
          ef[j] = ef[j-1]; et[j] = et[j-1]; ew[j] = ew[j-1];
          j--;
        end
        ef[j] = f; et[j] = t; ew[j] = w;
      end
      kruskal_run(n, edge_cnt, 1, sum, joined);
      r.tree = sum[SUM_W-1:0];
      found = 0;
      best = 0;
      for (int i = 0; i < edge_cnt; i++) begin
        if (!in_tree[i]) continue;
        kruskal_run(n, i, 0, sum, joined);
        if (joined == n - 1 && (!found || sum < best)) begin
          best = sum;
          found = 1;
        end
      end
      r.second = best[SUM_W-1:0];
      r.found = found;
      results_due.insert(results_due.size(), r);
    endfunction

    function void note_edge(logic [31:0] d, bit last);
      if (edge_cnt < MAX_E) begin
        ef[edge_cnt] = d[6:0];
        et[edge_cnt] = d[13:7];
        ew[edge_cnt] = $signed(d[29:14]);
        edge_cnt++;
      end
      if (last) begin
        compute_trees();
        edge_cnt = 0;
      end
    endfunction

    function void check_result(logic [47:0] d);
      mst_result_t r;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      r = results_due.pop_front();
      if (d[21:0] !== r.tree) begin
        $display("%0t: tree_weight exp %0d got %0d", $time, r.tree, $signed(d[21:0]));
        errors++;
      end
      if (d[43:22] !== r.second) begin
        $display("%0t: second_weight exp %0d got %0d", $time, r.second, $signed(d[43:22]));
        errors++;
      end
      if (d[44] !== r.found) begin
        $display("%0t: second_found exp %0d got %0d", $time, r.found, d[44]);
        errors++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [6:0]  cfg_wdata = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;   // from_vertex[6:0], to_vertex[13:7], edge_weight[29:14]
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;       // tree_weight[21:0], second_weight[43:22], second_found[44]
  logic        m_axis_tlast;

  mst_scoreboard sb = new();
  int            idle_cycles = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  int            stall_mode = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  kruskal_mst_second_best u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_edge(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // receiver stalls: switch pattern at random
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_edge(input int f, input int t, input int w, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_axis_tdata  <= {2'b00, w[15:0], t[6:0], f[6:0]};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // drain, hold intake, then write vertex_count
  task automatic write_vcount(input int v);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[6:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.vcount = v;
  endtask

  task automatic random_graph(input int ne, input bit noisy, input bit ties);
    int n, f, t, w;
    n = (sb.vcount < 1) ? 1 : (sb.vcount > MAX_V) ? MAX_V : sb.vcount;
    for (int k = 0; k < ne; k++) begin
      if (noisy && $urandom_range(0, 2) == 0) begin
        f = $urandom_range(0, 127);
        t = $urandom_range(0, 127);
      end else if (k < n - 1) begin
        // spanning backbone so later passes have real work
        f = k + 2;
        t = $urandom_range(1, k + 1);
        if ($urandom_range(0, 1)) begin f = t; t = k + 2; end
      end else begin
        f = $urandom_range(1, n);
        t = $urandom_range(1, n);
      end
      w = ties ? $urandom_range(0, 20) - 10 : $urandom_range(0, 65535);
      send_edge(f, t, w, k == ne - 1);
    end
  endtask

  initial begin
    int v, n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single vertex at reset count
    send_edge(1, 1, 5, 1);
    // count 0 acts as 1, bad endpoint
    write_vcount(0);
    send_edge(0, 1, -1, 1);
    // parallel edges, extreme weights, tie
    write_vcount(2);
    send_edge(1, 2, 32767, 0);
    send_edge(2, 1, -32768, 0);
    send_edge(1, 2, -32768, 1);
    // self loop, out-of-range endpoints, tree of bridges
    write_vcount(3);
    send_edge(1, 1, 7, 0);
    send_edge(1, 2, 3, 0);
    send_edge(3, 4, 1, 0);
    send_edge(127, 2, 0, 0);
    send_edge(2, 3, 32767, 1);
    // saturated count, star forest
    write_vcount(127);
    send_edge(64, 1, -32768, 0);
    send_edge(64, 2, -32768, 0);
    send_edge(2, 1, 100, 0);
    send_edge(65, 64, 5, 0);
    send_edge(63, 64, -7, 1);

    // full vertex range, then an overflowing edge store
    write_vcount(64);
    random_graph(70, 0, 0);
    random_graph(MAX_E + 4, 1, 0);

    while (items_sent < 900) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: v = $urandom_range(0, 127);
          1: v = 64;
          2: v = 1;
          default: v = $urandom_range(2, 10);
        endcase
        write_vcount(v);
      end
      n = (sb.vcount < 1) ? 1 : (sb.vcount > MAX_V) ? MAX_V : sb.vcount;
      if (n > 12 && $urandom_range(0, 3) != 0) n = 12;
      if ($urandom_range(0, 4) == 0)
        random_graph($urandom_range(1, 12), 1, $urandom_range(0, 1));
      else
        random_graph(n - 1 + $urandom_range(0, 8) + (n < 2), 0, $urandom_range(0, 1));
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: kruskal_mst_second_best.f
hw/rtl/kmsb_pkg.sv
hw/rtl/kmsb_datapath.sv
hw/rtl/kmsb_ctrl.sv
hw/rtl/kruskal_mst_second_best.sv
dv/tb_top.sv
